### src/upp_pkg.sv
// Shared constants, widths and the arctangent table for the unicycle pose propagator.
// No dependencies; every other file of the block imports this package.
package upp_pkg;

   // Default values of the top-level parameters.
   localparam int DEF_CORDIC_STAGES = 16;
   localparam int DEF_COORD_BITS    = 16;

   // Fixed widths of the transfer fields.
   localparam int SPEED_W = 12;
   localparam int RATE_W  = 15;
   localparam int DUR_W   = 15;
   localparam int HEAD_W  = 16;
   localparam int BOUND_W = 15;

   // Workspace bound after reset is 1.0 in unsigned Q3.12.
   localparam logic [BOUND_W-1:0] BOUND_RESET = 15'd4096;

   // Internal formats: distance Q.24, turn product Q.24 radians, vector Q2.30,
   // angle as a 32-bit binary angle.
   localparam int DIST_W      = SPEED_W + DUR_W;
   localparam int RATE_PROD_W = RATE_W + DUR_W + 1;
   localparam int XY_W        = 32;
   localparam int ANGLE_W     = 32;

   // Inverse CORDIC gain in Q2.30.
   localparam logic signed [XY_W-1:0] CORDIC_K = 32'sd652032874;

   // Radians to 32-bit binary angle, round(2^32 / 2pi).
   localparam int RAD_TO_BAM_W = 30;
   localparam logic [RAD_TO_BAM_W-1:0] RAD_TO_BAM = 30'd683565276;

   // Displacement product and its rescale from Q.54 to Q4.12.
   localparam int PROD_W   = DIST_W + 1 + XY_W;
   localparam int XY_SHIFT = 42;
   localparam int DISP_W   = PROD_W - XY_SHIFT;

   // Heading increment product and its rescale to 16-bit binary angle.
   localparam int HP_W    = RATE_PROD_W + RAD_TO_BAM_W + 1;
   localparam int H_SHIFT = 40;

   // Width of the side data that travels along the CORDIC chain:
   // start x, start y, distance, turn product, start heading, fold flag.
   function automatic int side_w(input int coord_bits);
      return 2 * coord_bits + DIST_W + RATE_PROD_W + HEAD_W + 1;
   endfunction

   // Arctangent of 2^-idx in units of 2^32 per full turn.
   function automatic logic [ANGLE_W-1:0] atan_bam32(input logic [4:0] idx);
      logic [ANGLE_W-1:0] a;
      case (idx)
         5'd0:    a = 32'd536870912;
         5'd1:    a = 32'd316933406;
         5'd2:    a = 32'd167458907;
         5'd3:    a = 32'd85004756;
         5'd4:    a = 32'd42667331;
         5'd5:    a = 32'd21354465;
         5'd6:    a = 32'd10679838;
         5'd7:    a = 32'd5340245;
         5'd8:    a = 32'd2670163;
         5'd9:    a = 32'd1335087;
         5'd10:   a = 32'd667544;
         5'd11:   a = 32'd333772;
         5'd12:   a = 32'd166886;
         5'd13:   a = 32'd83443;
         5'd14:   a = 32'd41722;
         5'd15:   a = 32'd20861;
         5'd16:   a = 32'd10430;
         5'd17:   a = 32'd5215;
         5'd18:   a = 32'd2608;
         5'd19:   a = 32'd1304;
         5'd20:   a = 32'd652;
         5'd21:   a = 32'd326;
         5'd22:   a = 32'd163;
         5'd23:   a = 32'd81;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

### src/upp_prep.sv
// Input stage of the pose propagator: distance and turn products, quarter-turn fold.
// Depends on upp_pkg.
module upp_prep import upp_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [COORD_BITS-1:0]   start_x,
   input  logic signed [COORD_BITS-1:0]   start_y,
   input  logic signed [HEAD_W-1:0]       start_heading,
   input  logic        [SPEED_W-1:0]      speed,
   input  logic signed [RATE_W-1:0]       turn_rate,
   input  logic        [DUR_W-1:0]        duration,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic signed [XY_W-1:0]         out_x,
   output logic signed [XY_W-1:0]         out_y,
   output logic signed [ANGLE_W-1:0]      out_z,
   output logic [side_w(COORD_BITS)-1:0]  out_side
);

   localparam int SIDE_W = side_w(COORD_BITS);

   logic                      load;
   logic                      valid_ff;
   logic                      fold;
   logic        [DIST_W-1:0]      dist_in;
   logic signed [RATE_PROD_W-1:0] turn_in;
   logic signed [ANGLE_W-1:0] z_in;
   logic signed [ANGLE_W-1:0] z_ff;
   logic [SIDE_W-1:0]         side_in;
   logic [SIDE_W-1:0]         side_ff;

   // The stage takes a new transfer when it is empty or its content moves on.
   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   // Headings beyond a quarter turn are moved by a half turn; the result is negated later.
   // The two top heading bits differ exactly in that case, and the move flips the sign bit.
   always_comb begin
      fold    = start_heading[HEAD_W-1] ^ start_heading[HEAD_W-2];
      z_in    = {start_heading[HEAD_W-1] ^ fold, start_heading[HEAD_W-2:0],
                 {(ANGLE_W-HEAD_W){1'b0}}};
      dist_in = DIST_W'(speed) * DIST_W'(duration);
      turn_in = RATE_PROD_W'(turn_rate) * signed'(RATE_PROD_W'(duration));
      side_in = {fold, start_heading, turn_in, dist_in, start_y, start_x};
   end

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load) begin
         z_ff    <= z_in;
         side_ff <= side_in;
      end
   end

   // The rotation always starts from the gain-compensated unit vector.
   assign out_valid = valid_ff;
   assign out_x     = CORDIC_K;
   assign out_y     = '0;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

### src/upp_cell.sv
// One CORDIC rotation cell with its own register; side data rides along unchanged.
// Depends on upp_pkg.
module upp_cell import upp_pkg::*; #(
   parameter int SHIFT  = 0,
   parameter int SIDE_W = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [XY_W-1:0]    in_x,
   input  logic signed [XY_W-1:0]    in_y,
   input  logic signed [ANGLE_W-1:0] in_z,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic signed [XY_W-1:0]    out_x,
   output logic signed [XY_W-1:0]    out_y,
   output logic signed [ANGLE_W-1:0] out_z,
   output logic [SIDE_W-1:0]         out_side
);

   localparam logic signed [ANGLE_W-1:0] ATAN_STEP = signed'(atan_bam32(5'(SHIFT)));

   logic                      load;
   logic                      valid_ff;
   logic                      turn_back;
   logic signed [XY_W-1:0]    x_in;
   logic signed [XY_W-1:0]    y_in;
   logic signed [ANGLE_W-1:0] z_in;
   logic signed [XY_W-1:0]    x_ff;
   logic signed [XY_W-1:0]    y_ff;
   logic signed [ANGLE_W-1:0] z_ff;
   logic [SIDE_W-1:0]         side_ff;

   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   // Rotate toward zero residual angle; shifts are arithmetic (floor).
   always_comb begin
      turn_back = in_z[ANGLE_W-1];
      if (turn_back) begin
         x_in = in_x + (in_y >>> SHIFT);
         y_in = in_y - (in_x >>> SHIFT);
         z_in = in_z + ATAN_STEP;
      end else begin
         x_in = in_x - (in_y >>> SHIFT);
         y_in = in_y + (in_x >>> SHIFT);
         z_in = in_z - ATAN_STEP;
      end
   end

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

### src/upp_post.sv
// Back end of the pose propagator: unfold, scale by distance, round, offset and clamp.
// Depends on upp_pkg.
module upp_post import upp_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [BOUND_W-1:0]            bound,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [XY_W-1:0]        in_x,
   input  logic signed [XY_W-1:0]        in_y,
   input  logic [side_w(COORD_BITS)-1:0] in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_BITS-1:0]  new_x,
   output logic signed [COORD_BITS-1:0]  new_y,
   output logic signed [HEAD_W-1:0]      new_heading
);

   localparam int NUM_STAGES = 4;
   localparam int OFS_SY     = COORD_BITS;
   localparam int OFS_DIST   = 2 * COORD_BITS;
   localparam int OFS_TURN   = OFS_DIST + DIST_W;
   localparam int OFS_HD     = OFS_TURN + RATE_PROD_W;
   localparam int OFS_FLIP   = OFS_HD + HEAD_W;
   localparam int SUM_W      = ((COORD_BITS > DISP_W) ? COORD_BITS : DISP_W) + 1;
   localparam logic signed [PROD_W-1:0] HALF_X = PROD_W'(1) <<< (XY_SHIFT - 1);
   localparam logic signed [HP_W-1:0]   HALF_H = HP_W'(1) <<< (H_SHIFT - 1);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] rdy;

   // Side data unpacked.
   logic signed [COORD_BITS-1:0]  side_sx;
   logic signed [COORD_BITS-1:0]  side_sy;
   logic        [DIST_W-1:0]      side_dist;
   logic signed [RATE_PROD_W-1:0] side_turn;
   logic signed [HEAD_W-1:0]      side_hd;
   logic                          side_flip;

   // Stage 0: unfolded cosine and sine.
   logic signed [XY_W-1:0]        c0_in, s0_in, c0_ff, s0_ff;
   logic        [DIST_W-1:0]      dist0_ff;
   logic signed [RATE_PROD_W-1:0] turn0_ff;
   logic signed [COORD_BITS-1:0]  sx0_ff, sy0_ff;
   logic signed [HEAD_W-1:0]      hd0_ff;

   // Stage 1: products.
   logic signed [PROD_W-1:0]      dist_ext;
   logic signed [PROD_W-1:0]      mx1_in, my1_in, mx1_ff, my1_ff;
   logic signed [HP_W-1:0]        mh1_in, mh1_ff;
   logic signed [COORD_BITS-1:0]  sx1_ff, sy1_ff;
   logic signed [HEAD_W-1:0]      hd1_ff;

   // Stage 2: rounded displacement and heading step.
   logic signed [PROD_W-1:0]      rx_sum, ry_sum;
   logic signed [HP_W-1:0]        rh_sum;
   logic signed [DISP_W-1:0]      dx2_ff, dy2_ff;
   logic signed [HEAD_W-1:0]      dh2_ff;
   logic signed [COORD_BITS-1:0]  sx2_ff, sy2_ff;
   logic signed [HEAD_W-1:0]      hd2_ff;

   // Stage 3: result registers.
   logic signed [SUM_W-1:0]       bnd_pos, bnd_neg, px_sum, py_sum, px_clamp, py_clamp;
   logic signed [COORD_BITS-1:0]  nx3_in, ny3_in, nx3_ff, ny3_ff;
   logic signed [HEAD_W-1:0]      nh3_in, nh3_ff;

   // A stage loads when it is empty or the stage after it loads.
   always_comb begin
      rdy[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end
   assign in_ready = rdy[0];

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // Undo the half-turn fold by negating the vector.
   always_comb begin
      side_sx   = signed'(in_side[OFS_SY-1:0]);
      side_sy   = signed'(in_side[OFS_DIST-1:OFS_SY]);
      side_dist = in_side[OFS_TURN-1:OFS_DIST];
      side_turn = signed'(in_side[OFS_HD-1:OFS_TURN]);
      side_hd   = signed'(in_side[OFS_FLIP-1:OFS_HD]);
      side_flip = in_side[OFS_FLIP];
      c0_in     = side_flip ? -in_x : in_x;
      s0_in     = side_flip ? -in_y : in_y;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         c0_ff    <= c0_in;
         s0_ff    <= s0_in;
         dist0_ff <= side_dist;
         turn0_ff <= side_turn;
         sx0_ff   <= side_sx;
         sy0_ff   <= side_sy;
         hd0_ff   <= side_hd;
      end
   end

   // Distance times cosine and sine, turn product times radians-to-angle factor.
   always_comb begin
      dist_ext = signed'(PROD_W'(dist0_ff));
      mx1_in   = dist_ext * PROD_W'(c0_ff);
      my1_in   = dist_ext * PROD_W'(s0_ff);
      mh1_in   = HP_W'(turn0_ff) * signed'(HP_W'(RAD_TO_BAM));
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         mx1_ff <= mx1_in;
         my1_ff <= my1_in;
         mh1_ff <= mh1_in;
         sx1_ff <= sx0_ff;
         sy1_ff <= sy0_ff;
         hd1_ff <= hd0_ff;
      end
   end

   // Rounding half away from zero: add half, less one for negative values, then floor.
   always_comb begin
      rx_sum = mx1_ff + HALF_X - signed'(PROD_W'(mx1_ff[PROD_W-1]));
      ry_sum = my1_ff + HALF_X - signed'(PROD_W'(my1_ff[PROD_W-1]));
      rh_sum = mh1_ff + HALF_H - signed'(HP_W'(mh1_ff[HP_W-1]));
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         dx2_ff <= rx_sum[PROD_W-1:XY_SHIFT];
         dy2_ff <= ry_sum[PROD_W-1:XY_SHIFT];
         dh2_ff <= rh_sum[H_SHIFT+HEAD_W-1:H_SHIFT];
         sx2_ff <= sx1_ff;
         sy2_ff <= sy1_ff;
         hd2_ff <= hd1_ff;
      end
   end

   // Offset from the start pose, clamp to the workspace, wrap the heading.
   always_comb begin
      bnd_pos = signed'(SUM_W'(bound));
      bnd_neg = -bnd_pos;
      px_sum  = SUM_W'(sx2_ff) + SUM_W'(dx2_ff);
      py_sum  = SUM_W'(sy2_ff) + SUM_W'(dy2_ff);
      if (px_sum > bnd_pos) begin
         px_clamp = bnd_pos;
      end else if (px_sum < bnd_neg) begin
         px_clamp = bnd_neg;
      end else begin
         px_clamp = px_sum;
      end
      if (py_sum > bnd_pos) begin
         py_clamp = bnd_pos;
      end else if (py_sum < bnd_neg) begin
         py_clamp = bnd_neg;
      end else begin
         py_clamp = py_sum;
      end
      nx3_in = COORD_BITS'(px_clamp);
      ny3_in = COORD_BITS'(py_clamp);
      nh3_in = hd2_ff + dh2_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         nx3_ff <= nx3_in;
         ny3_ff <= ny3_in;
         nh3_ff <= nh3_in;
      end
   end

   assign out_valid   = valid_ff[NUM_STAGES-1];
   assign new_x       = nx3_ff;
   assign new_y       = ny3_ff;
   assign new_heading = nh3_ff;

endmodule

### src/unicycle_pose_propagate.sv
// Throughput: one transfer per cycle while rsp_stall is low; every CORDIC iteration is a
// cell of its own in the chain. The ready path runs back through every stage without a
// register, so bubbles are squeezed out and a waiting result blocks new input only once
// every stage is full. Reset clears all valid flags and sets the workspace bound to 1.0.
// Top level; depends on upp_pkg, upp_prep, upp_cell and upp_post.
module unicycle_pose_propagate import upp_pkg::*; #(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
   parameter int COORD_BITS    = DEF_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   // Configuration port.
   input  logic                         csr_wr_en,
   input  logic [BOUND_W-1:0]           csr_wr_data,
   // Input channel.
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [HEAD_W-1:0]     req_start_heading,
   input  logic        [SPEED_W-1:0]    req_speed,
   input  logic signed [RATE_W-1:0]     req_turn_rate,
   input  logic        [DUR_W-1:0]      req_duration,
   // Result channel.
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_new_x,
   output logic signed [COORD_BITS-1:0] rsp_new_y,
   output logic signed [HEAD_W-1:0]     rsp_new_heading
);

   localparam int SIDE_W = side_w(COORD_BITS);

   logic [BOUND_W-1:0]        bound_ff;
   logic                      prep_ready;

   // Chain links: index 0 is the input stage output, index i+1 is cell i output.
   logic [CORDIC_STAGES:0]    cv;
   logic [CORDIC_STAGES:0]    cr;
   logic signed [XY_W-1:0]    cx    [CORDIC_STAGES+1];
   logic signed [XY_W-1:0]    cy    [CORDIC_STAGES+1];
   logic signed [ANGLE_W-1:0] cz    [CORDIC_STAGES+1];
   logic [SIDE_W-1:0]         cside [CORDIC_STAGES+1];

   // Workspace bound register.
   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff <= BOUND_RESET;
      end else if (csr_wr_en) begin
         bound_ff <= csr_wr_data;
      end
   end

   assign req_stall = !prep_ready;

   // Input stage.
   upp_prep #(
      .COORD_BITS (COORD_BITS)
   ) u_prep (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (prep_ready),
      .start_x       (req_start_x),
      .start_y       (req_start_y),
      .start_heading (req_start_heading),
      .speed         (req_speed),
      .turn_rate     (req_turn_rate),
      .duration      (req_duration),
      .out_valid     (cv[0]),
      .out_ready     (cr[0]),
      .out_x         (cx[0]),
      .out_y         (cy[0]),
      .out_z         (cz[0]),
      .out_side      (cside[0])
   );

   // CORDIC chain, one iteration per cell.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      upp_cell #(
         .SHIFT  (i),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[i]),
         .in_ready  (cr[i]),
         .in_x      (cx[i]),
         .in_y      (cy[i]),
         .in_z      (cz[i]),
         .in_side   (cside[i]),
         .out_valid (cv[i+1]),
         .out_ready (cr[i+1]),
         .out_x     (cx[i+1]),
         .out_y     (cy[i+1]),
         .out_z     (cz[i+1]),
         .out_side  (cside[i+1])
      );
   end

   // Back end and result register.
   upp_post #(
      .COORD_BITS (COORD_BITS)
   ) u_post (
      .clock       (clock),
      .reset       (reset),
      .bound       (bound_ff),
      .in_valid    (cv[CORDIC_STAGES]),
      .in_ready    (cr[CORDIC_STAGES]),
      .in_x        (cx[CORDIC_STAGES]),
      .in_y        (cy[CORDIC_STAGES]),
      .in_side     (cside[CORDIC_STAGES]),
      .out_valid   (rsp_valid),
      .out_ready   (!rsp_stall),
      .new_x       (rsp_new_x),
      .new_y       (rsp_new_y),
      .new_heading (rsp_new_heading)
   );

   // Reset empties the whole pipeline, so no result follows it.
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // With the result side free, the ready chain must reach the input.
   a_free_flow: assert property (@(posedge clock) !rsp_stall |-> !req_stall)
      else $error("input stalled while the result side takes transfers");

   // A configuration write lands in the bound register.
   a_bound_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> bound_ff == $past(csr_wr_data))
      else $error("workspace bound not updated by a write");

endmodule
